// File: rtl/core/upwind_fd_stencil_coeffs_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the upwind stencil coefficient block
// Same-cycle and next-cycle implication checks with synchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef UPWIND_FD_STENCIL_COEFFS_ASSERT_SVH
`define UPWIND_FD_STENCIL_COEFFS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define UFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the next cycle
`define UFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: rtl/core/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types, defaults and saturation helpers for the stencil pipeline.
// ----------------------------------------------------------------------------
package ufd_pkg;

    localparam int IN_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        POS_FIRST = 2'd0,
        POS_INNER = 2'd1,
        POS_LAST  = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2
    } t_op;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // magnitude is clipped to 2^63; bit 63 set means at or beyond the limit
    function automatic logic signed [63:0] sat_signed(input logic [63:0] mag,
                                                      input logic neg);
        logic signed [63:0] res;
        if (neg) begin
            res = mag[63] ? SAT_MIN : -$signed(mag);
        end else begin
            res = mag[63] ? SAT_MAX : $signed(mag);
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_apply(input logic signed [63:0] x,
                                                     input logic signed [63:0] v,
                                                     input t_op op);
        logic signed [64:0] s;
        logic signed [63:0] res;
        s = 65'sd0;
        case (op)
            OP_ADD:  s = {x[63], x} + {v[63], v};
            OP_SUB:  s = {x[63], x} - {v[63], v};
            default: s = {x[63], x};
        endcase
        if (s[64] != s[63]) begin
            res = s[64] ? SAT_MIN : SAT_MAX;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/ufd_div.sv
// ----------------------------------------------------------------------------
// ufd_div
// Pipelined restoring divider, one quotient bit per stage, then a rounding
// stage (half away from zero on magnitudes) with the result clipped at 2^63.
// ----------------------------------------------------------------------------
module ufd_div #(
    parameter int NUM_W = 94,
    parameter int DEN_W = 65
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [63:0]      o_mag
);
    localparam int RW = DEN_W + 1;
    localparam int XW = (NUM_W + 1 > 64) ? NUM_W + 1 : 64;

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [RW-1:0]    r_rem [NUM_W];
    logic [63:0]      r_mag;

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [NUM_W-1:0] w_nin, w_qin;
        logic [DEN_W-1:0] w_din;
        logic [RW-1:0]    w_rin, w_sh, n_rem;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_nin = i_num;
            assign w_qin = '0;
            assign w_din = i_den;
            assign w_rin = '0;
        end else begin : g_rest
            assign w_nin = r_num[k-1];
            assign w_qin = r_quo[k-1];
            assign w_din = r_den[k-1];
            assign w_rin = r_rem[k-1];
        end

        always_comb begin
            w_sh  = {w_rin[RW-2:0], w_nin[NUM_W-1]};
            w_ge  = (w_sh >= {1'b0, w_din});
            n_rem = w_ge ? (w_sh - {1'b0, w_din}) : w_sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {w_nin[NUM_W-2:0], 1'b0};
                r_quo[k] <= {w_qin[NUM_W-2:0], w_ge};
                r_den[k] <= w_din;
                r_rem[k] <= n_rem;
            end
        end
    end

    logic             w_up;
    logic [NUM_W:0]   w_qr;
    logic [XW-1:0]    w_qx;

    always_comb begin
        w_up = ({r_rem[NUM_W-1][RW-2:0], 1'b0} >= {1'b0, r_den[NUM_W-1]});
        w_qr = {1'b0, r_quo[NUM_W-1]} + (NUM_W+1)'(w_up);
        w_qx = XW'(w_qr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_qx >= (XW'(1) << 63)) begin
                r_mag <= 64'h8000_0000_0000_0000;
            end else begin
                r_mag <= w_qx[63:0];
            end
        end
    end

    assign o_mag = r_mag;

endmodule

// File: rtl/core/upwind_fd_stencil_coeffs.sv
// ----------------------------------------------------------------------------
// upwind_fd_stencil_coeffs
// Tridiagonal upwind/central stencil coefficients on a nonuniform grid.
//
// Channel   Dir  Contents
// s_axis    in   tdata: node_prev, node_cur, node_next, drift, diffusion
//                tuser: position
// m_axis    out  tdata: lower, diagonal, upper; tuser: spacing_error
// cfg       in   wr_en / wr_data: central_only
//
// One beat per cycle sustained while m_axis does not stall. The pipeline is the four
// bit-per-stage dividers (2*IN_WIDTH+30 steps plus rounding) with two stages
// before and after them.
// Reset is synchronous, active low, and clears valid bits and central_only.
// A stall on m_axis freezes the whole pipeline; s_axis tready drops with it.
// ----------------------------------------------------------------------------
`include "upwind_fd_stencil_coeffs_assert.svh"

module upwind_fd_stencil_coeffs #(
    parameter int IN_WIDTH = ufd_pkg::IN_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // node_prev, node_cur, node_next, drift, diffusion (from bit 0 up)
    input  logic [((5*IN_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // position
    input  logic [1:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // lower, diagonal, upper (from bit 0 up)
    output logic [191:0]                         o_m_axis_tdata,
    // spacing_error
    output logic [0:0]                           o_m_axis_tuser
);
    import ufd_pkg::*;

    localparam int W   = IN_WIDTH;
    localparam int NW  = 2*W + 30;
    localparam int DW  = 2*W + 1;
    localparam int LAT = NW + 1;

    typedef struct packed {
        logic       vld;
        logic       aneg;
        logic [1:0] pos;
        logic       cen;
        logic       err;
    } t_side;

    logic r_cen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cen <= i_cfg_wr_data;
        end
    end

    logic w_en;
    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    // take no beat while in reset
    assign o_s_axis_tready = w_en && i_rst_n;

    // ---------------- stage 0: spacings, magnitudes, error ----------------
    logic signed [W-1:0] w_prev, w_cur, w_next, w_a, w_s;
    logic signed [W:0]   w_hu, w_hd, w_hc;
    logic                w_hu_pos, w_hd_pos, w_err;
    t_side               n_s0_sd;

    always_comb begin
        w_prev = i_s_axis_tdata[W-1:0];
        w_cur  = i_s_axis_tdata[2*W-1:W];
        w_next = i_s_axis_tdata[3*W-1:2*W];
        w_a    = i_s_axis_tdata[4*W-1:3*W];
        w_s    = i_s_axis_tdata[5*W-1:4*W];
        w_hu   = {w_next[W-1], w_next} - {w_cur[W-1], w_cur};
        w_hd   = {w_cur[W-1], w_cur} - {w_prev[W-1], w_prev};
        w_hc   = {w_next[W-1], w_next} - {w_prev[W-1], w_prev};
        w_hu_pos = !w_hu[W] && (|w_hu);
        w_hd_pos = !w_hd[W] && (|w_hd);
        case (i_s_axis_tuser)
            POS_FIRST: w_err = !w_hu_pos;
            POS_LAST:  w_err = !w_hd_pos;
            POS_INNER: w_err = !w_hu_pos || !w_hd_pos;
            default:   w_err = 1'b0;
        endcase
        n_s0_sd.vld  = i_s_axis_tvalid && o_s_axis_tready;
        n_s0_sd.aneg = w_a[W-1];
        n_s0_sd.pos  = i_s_axis_tuser;
        n_s0_sd.cen  = r_cen;
        n_s0_sd.err  = w_err;
    end

    t_side           r_s0_sd;
    logic [W:0]      r_s0_hu, r_s0_hd, r_s0_hc;
    logic [W-1:0]    r_s0_amag, r_s0_smag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_sd <= '0;
        end else if (w_en) begin
            r_s0_sd <= n_s0_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_hu   <= w_hu;
            r_s0_hd   <= w_hd;
            r_s0_hc   <= w_hc;
            r_s0_amag <= w_a[W-1] ? W'(-w_a) : w_a;
            r_s0_smag <= w_s[W-1] ? W'(-w_s) : w_s;
        end
    end

    // ---------------- stage 1: squares and spacing product ----------------
    t_side           r_s1_sd;
    logic [W:0]      r_s1_hu, r_s1_hd, r_s1_hc;
    logic [W-1:0]    r_s1_amag;
    logic [2*W-1:0]  r_s1_sq, r_s1_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_sd <= '0;
        end else if (w_en) begin
            r_s1_sd <= r_s0_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_hu   <= r_s0_hu;
            r_s1_hd   <= r_s0_hd;
            r_s1_hc   <= r_s0_hc;
            r_s1_amag <= r_s0_amag;
            r_s1_sq   <= r_s0_smag * r_s0_smag;
            r_s1_pp   <= r_s0_hu[W-1:0] * r_s0_hd[W-1:0];
        end
    end

    // ---------------- dividers ----------------
    logic [NW-1:0] w_num_a, w_num_b;
    logic [63:0]   w_m_up, w_m_dn, w_m_c, w_m_b;

    assign w_num_a = NW'({r_s1_amag, 32'd0});
    assign w_num_b = {r_s1_sq[2*W-2:0], 31'd0};

    ufd_div #(.NUM_W(NW), .DEN_W(DW)) u_div_up (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_a),
        .i_den(DW'(r_s1_hu[W-1:0])), .o_mag(w_m_up));
    ufd_div #(.NUM_W(NW), .DEN_W(DW)) u_div_dn (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_a),
        .i_den(DW'(r_s1_hd[W-1:0])), .o_mag(w_m_dn));
    ufd_div #(.NUM_W(NW), .DEN_W(DW)) u_div_c (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_a),
        .i_den(DW'(r_s1_hc)), .o_mag(w_m_c));
    ufd_div #(.NUM_W(NW), .DEN_W(DW)) u_div_b (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_b),
        .i_den(DW'(r_s1_pp)), .o_mag(w_m_b));

    // side info travels alongside the divider stages
    t_side r_sd [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_sd[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_sd[0] <= r_s1_sd;
            for (int k = 1; k < LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // ---------------- combine 1: pick branch and operands ----------------
    t_side              w_sd;
    logic signed [63:0] w_f, w_g, w_c, w_b, w_n2b;
    logic signed [63:0] n_lo, n_di, n_up, n_v;
    t_op                n_op_lo, n_op_di, n_op_up;

    always_comb begin
        w_sd  = r_sd[LAT-1];
        w_f   = sat_signed(w_m_up, w_sd.aneg);
        w_g   = sat_signed(w_m_dn, w_sd.aneg);
        w_c   = sat_signed(w_m_c, w_sd.aneg);
        w_b   = sat_signed(w_m_b, 1'b0);
        w_n2b = (w_b > 64'sh4000_0000_0000_0000) ? SAT_MIN : -(w_b <<< 1);
        n_lo = '0;
        n_di = '0;
        n_up = '0;
        n_v  = '0;
        n_op_lo = OP_NONE;
        n_op_di = OP_NONE;
        n_op_up = OP_NONE;
        if (!w_sd.err) begin
            case (w_sd.pos)
                POS_FIRST: begin
                    n_di = w_f;
                    n_v  = w_f;
                    n_op_lo = OP_SUB;
                end
                POS_LAST: begin
                    n_up = w_g;
                    n_v  = w_g;
                    n_op_di = OP_SUB;
                end
                POS_INNER: begin
                    n_lo = w_b;
                    n_di = w_n2b;
                    n_up = w_b;
                    if (!w_sd.cen && (w_c > w_b)) begin
                        n_v = w_f;
                        n_op_di = OP_SUB;
                        n_op_up = OP_ADD;
                    end else if (!w_sd.cen && (w_c < -w_b)) begin
                        n_v = w_g;
                        n_op_lo = OP_SUB;
                        n_op_di = OP_ADD;
                    end else begin
                        n_v = w_c;
                        n_op_lo = OP_SUB;
                        n_op_up = OP_ADD;
                    end
                end
                default: begin
                    n_v = '0;
                end
            endcase
        end
    end

    logic               r_c1_vld, r_c1_err;
    logic signed [63:0] r_c1_lo, r_c1_di, r_c1_up, r_c1_v;
    t_op                r_c1_op_lo, r_c1_op_di, r_c1_op_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (w_en) begin
            r_c1_vld <= w_sd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_err   <= w_sd.err;
            r_c1_lo    <= n_lo;
            r_c1_di    <= n_di;
            r_c1_up    <= n_up;
            r_c1_v     <= n_v;
            r_c1_op_lo <= n_op_lo;
            r_c1_op_di <= n_op_di;
            r_c1_op_up <= n_op_up;
        end
    end

    // ---------------- combine 2: saturating update into output ----------------
    logic               r_ovld, r_oerr;
    logic signed [63:0] r_olo, r_odi, r_oup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oerr <= r_c1_err;
            r_olo  <= sat_apply(r_c1_lo, r_c1_v, r_c1_op_lo);
            r_odi  <= sat_apply(r_c1_di, r_c1_v, r_c1_op_di);
            r_oup  <= sat_apply(r_c1_up, r_c1_v, r_c1_op_up);
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {r_oup, r_odi, r_olo};
    assign o_m_axis_tuser  = r_oerr;

    // ---------------- assertions ----------------
    `UFD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 192'd0)
    `UFD_ASSERT_NEXT(a_c1_to_out, i_clk, i_rst_n, r_c1_vld && w_en, o_m_axis_tvalid)
    `UFD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, r_c1_vld == $past(r_c1_vld))

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the upwind stencil coefficient block: directed corner
// nodes, then random grid nodes under both drift modes and several idle mixes,
// each result checked against an in-bench fixed-point coefficient predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import ufd_pkg::*;

    localparam int LAT_WAIT   = 130;
    localparam int STALL_LIMIT = 20000;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] prev;
        logic signed [31:0] cur;
        logic signed [31:0] next;
        logic signed [31:0] drift;
        logic signed [31:0] diff;
        logic [1:0]         pos;
    } t_node;

    typedef struct packed {
        logic signed [63:0] lower;
        logic signed [63:0] diag;
        logic signed [63:0] upper;
        logic               bad_h;
    } t_coeff;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wd = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [159:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [191:0] m_data;
    logic [0:0]   m_user;

    t_node  node_pending[$];
    t_coeff coeff_expected[$];
    t_node  node_on_bus;
    logic   mode_central = 1'b0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     n_errors = 0;
    int     n_checked = 0;
    int     n_flagged = 0;
    int     quiet_cycles = 0;
    bit     beat_in = 1'b0;

    upwind_fd_stencil_coeffs dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_wr_data   (cfg_wd),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [63:0] clip(input logic signed [64:0] s);
        if (s > 65'sd9223372036854775807) return Q_MAX;
        if (s < -65'sd9223372036854775808) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        return clip(65'(x) + 65'(y));
    endfunction

    function automatic logic signed [63:0] q_sub(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        return clip(65'(x) - 65'(y));
    endfunction

    // rounded magnitude quotient, halves away from zero, then signed clip
    function automatic logic signed [63:0] rdiv(input logic [127:0] num,
                                                input logic [127:0] den,
                                                input logic neg);
        logic [127:0] q;
        logic [127:0] r;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den) q = q + 1;
        if (q >= (128'd1 << 63)) return neg ? Q_MIN : Q_MAX;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] slope(input logic signed [63:0] a,
                                                 input logic signed [63:0] h);
        logic [63:0] m;
        m = (a < 0) ? 64'(-a) : 64'(a);
        return rdiv({64'd0, m} << 32, {64'd0, h}, a < 0);
    endfunction

    function automatic t_coeff stencil_coeffs(input t_node n, input logic central);
        t_coeff c;
        logic signed [63:0] hu, hd, hc, b, cc, a;
        logic [63:0] sm;
        c = '0;
        a  = 64'(n.drift);
        hu = 64'(n.next) - 64'(n.cur);
        hd = 64'(n.cur) - 64'(n.prev);
        hc = 64'(n.next) - 64'(n.prev);
        if (n.pos == POS_FIRST) begin
            if (hu <= 0) c.bad_h = 1'b1;
            else begin
                cc = slope(a, hu);
                c.lower = q_sub(0, cc);
                c.diag = cc;
            end
        end else if (n.pos == POS_LAST) begin
            if (hd <= 0) c.bad_h = 1'b1;
            else begin
                cc = slope(a, hd);
                c.diag = q_sub(0, cc);
                c.upper = cc;
            end
        end else if (n.pos == POS_INNER) begin
            if (hu <= 0 || hd <= 0) c.bad_h = 1'b1;
            else begin
                sm = (n.diff < 0) ? 64'(-64'(n.diff)) : 64'(n.diff);
                b = rdiv((128'(sm) * 128'(sm)) << 31, 128'(hu) * 128'(hd), 1'b0);
                cc = slope(a, hc);
                c.lower = b;
                c.diag = q_sub(q_sub(0, b), b);
                c.upper = b;
                if (!central && cc > b) begin
                    c.diag = q_sub(c.diag, slope(a, hu));
                    c.upper = q_add(c.upper, slope(a, hu));
                end else if (!central && cc < -b) begin
                    c.lower = q_sub(c.lower, slope(a, hd));
                    c.diag = q_add(c.diag, slope(a, hd));
                end else begin
                    c.lower = q_sub(c.lower, cc);
                    c.upper = q_add(c.upper, cc);
                end
            end
        end
        return c;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    endtask

    // driver: advance to the next node once the current beat is taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_valid || beat_in) begin
                if (node_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    node_on_bus = node_pending.pop_front();
                    s_data <= {node_on_bus.diff, node_on_bus.drift, node_on_bus.next,
                               node_on_bus.cur, node_on_bus.prev};
                    s_user <= node_on_bus.pos;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge clk) begin
        t_coeff want;
        beat_in = s_valid && s_ready;
        if (beat_in) coeff_expected.push_back(stencil_coeffs(node_on_bus, mode_central));
        if (m_valid && m_ready) begin
            if (coeff_expected.size() == 0) begin
                report("unexpected beat", m_data[63:0], 64'd0);
            end else begin
                want = coeff_expected.pop_front();
                if (m_data[63:0] !== want.lower) report("lower", m_data[63:0], want.lower);
                if (m_data[127:64] !== want.diag) report("diagonal", m_data[127:64], want.diag);
                if (m_data[191:128] !== want.upper)
                    report("upper", m_data[191:128], want.upper);
                if (m_user[0] !== want.bad_h)
                    report("spacing_error", 64'(m_user), 64'(want.bad_h));
                if (want.bad_h) n_flagged++;
                n_checked++;
            end
        end
        if (beat_in || (m_valid && m_ready) ||
            (node_pending.size() == 0 && coeff_expected.size() == 0 && !s_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: pipeline stuck");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_node mk(input logic signed [31:0] p, input logic signed [31:0] c,
                                 input logic signed [31:0] n, input logic signed [31:0] a,
                                 input logic signed [31:0] s, input logic [1:0] pos);
        t_node r;
        r.prev = p; r.cur = c; r.next = n; r.drift = a; r.diff = s; r.pos = pos;
        return r;
    endfunction

    function automatic logic signed [31:0] rnd_val();
        return $signed($urandom) >>> $urandom_range(31, 0);
    endfunction

    function automatic t_node rnd_node();
        t_node r;
        logic signed [31:0] hu, hd;
        r.cur = $signed($urandom) >>> $urandom_range(31, 1);
        hu = $urandom_range(3) == 0 ? $unsigned(rnd_val()) >> $urandom_range(20, 0)
                                    : 32'($urandom_range(65536 * 8, 1));
        hd = $urandom_range(3) == 0 ? $unsigned(rnd_val()) >> $urandom_range(20, 0)
                                    : 32'($urandom_range(65536 * 8, 1));
        if ($urandom_range(19) == 0) hu = -rnd_val();
        if ($urandom_range(19) == 0) hd = 0;
        r.next = r.cur + hu;
        r.prev = r.cur - hd;
        r.drift = rnd_val();
        r.diff = rnd_val();
        r.pos = ($urandom_range(39) == 0) ? 2'd3 : 2'($urandom_range(2));
        if ($urandom_range(15) == 0) begin
            r.prev = $urandom; r.cur = $urandom; r.next = $urandom;
            r.drift = $urandom; r.diff = $urandom;
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (node_pending.size() > 0 || coeff_expected.size() > 0 || s_valid)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic set_mode(input logic central);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wd = central;
        @(negedge clk);
        cfg_we = 1'b0;
        mode_central = central;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            send_idle = (ph == 0) ? 23 : (ph == 1) ? 62 : 0;
            recv_idle = (ph == 0) ? 62 : (ph == 1) ? 23 : 0;
            if (ph == 0) begin
                // corner nodes: saturation, bad spacing, all drift branches
                node_pending.push_back(mk(0, 0, 1, 32'sh7FFFFFFF, 0, POS_FIRST));
                node_pending.push_back(mk(0, 0, 1, 32'sh80000000, 0, POS_FIRST));
                node_pending.push_back(mk(-1, 0, 0, 5, 5, POS_FIRST));
                node_pending.push_back(mk(0, 0, 9, 32'sh80000000, 0, POS_LAST));
                node_pending.push_back(mk(7, 3, 9, 65536, 0, POS_LAST));
                node_pending.push_back(mk(-1, 0, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, POS_INNER));
                node_pending.push_back(mk(-1, 0, 1, 0, 32'sh80000000, POS_INNER));
                node_pending.push_back(mk(32'sh80000000, 0, 32'sh7FFFFFFF,
                                          32'sh7FFFFFFF, 32'sh7FFFFFFF, POS_INNER));
                node_pending.push_back(mk(-65536, 0, 65536, 32'sh00100000, 100, POS_INNER));
                node_pending.push_back(mk(-65536, 0, 65536, -32'sh00100000, 100, POS_INNER));
                node_pending.push_back(mk(-65536, 0, 65536, 1000, 65536, POS_INNER));
                node_pending.push_back(mk(-65536, 0, 131072, 3, 3, POS_INNER));
                node_pending.push_back(mk(0, 0, 65536, 1, 1, POS_INNER));
                node_pending.push_back(mk(0, 5, 5, 1, 1, POS_INNER));
                node_pending.push_back(mk(1, 2, 3, 4, 5, 2'd3));
                node_pending.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                          32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3));
                node_pending.push_back(mk(0, 1, 2, 1, 0, POS_FIRST));
                node_pending.push_back(mk(0, 1, 2, -1, 0, POS_LAST));
            end
            for (int k = 0; k < 135; k++) node_pending.push_back(rnd_node());
            wait_idle();
        end

        $display("checked %0d coefficient beats (%0d with bad spacing)", n_checked, n_flagged);
        $display("covered hybrid and central drift, sender and receiver stalls");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
